// ===== design/mideq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mideq_pkg
// Shared widths, register codes and defaults of the input qualifier.
// ----------------------------------------------------------------------------
package mideq_pkg;

  localparam int BUTTONS_DEF    = 4;
  localparam int SENSORS_DEF    = 2;
  localparam int LIMITS_DEF     = 2;

  localparam int TIME_W         = 32;
  localparam int MS_W           = 16;
  localparam int DIST_W         = 12;
  localparam int ANALOG_BITS    = 10;
  localparam int MM_PER_CM      = 10;
  localparam int DIFF_MM_W      = DIST_W + 4;

  localparam int POL_BUTTON     = 0;
  localparam int POL_BEAM       = 1;
  localparam int POL_LIMIT      = 2;
  localparam int POL_SENSOR_LSB = 3;

  localparam int REG_IDX_W      = 3;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POLARITY  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SNS_MODE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SNS_THR   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOCKOUT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ECHO_INTV = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ECHO_DLT  = 3'd6;

  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd20;

  typedef struct packed {
    logic [MS_W-1:0] interval;
    logic [MS_W-1:0] delta;
  } echo_cfg_t;

endpackage
`default_nettype wire

// ===== design/mideq_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mideq_in_if
// Input channel: one tick of timestamp and raw levels per transaction.
// ----------------------------------------------------------------------------
interface mideq_in_if
  import mideq_pkg::*;
#(
  parameter int BUTTONS = BUTTONS_DEF,
  parameter int SENSORS = SENSORS_DEF,
  parameter int LIMITS  = LIMITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [TIME_W-1:0]              now_ms;
  logic [BUTTONS-1:0]             button_levels;
  logic                           beam_level;
  logic [LIMITS-1:0]              limit_levels;
  logic [DIST_W-1:0]              echo_distance_cm;
  logic [SENSORS-1:0]             sensor_digital_levels;
  logic [ANALOG_BITS*SENSORS-1:0] sensor_raw_values;

  modport source (
    output valid, now_ms, button_levels, beam_level, limit_levels,
           echo_distance_cm, sensor_digital_levels, sensor_raw_values,
    input  ready
  );
  modport sink (
    input  valid, now_ms, button_levels, beam_level, limit_levels,
           echo_distance_cm, sensor_digital_levels, sensor_raw_values,
    output ready
  );
endinterface
`default_nettype wire

// ===== design/mideq_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mideq_out_if
// Result channel: qualified levels and edges, one transaction per tick.
// ----------------------------------------------------------------------------
interface mideq_out_if
  import mideq_pkg::*;
#(
  parameter int BUTTONS = BUTTONS_DEF,
  parameter int SENSORS = SENSORS_DEF,
  parameter int LIMITS  = LIMITS_DEF
);
  logic               valid;
  logic               ready;
  logic [BUTTONS-1:0] buttons_down;
  logic [BUTTONS-1:0] button_press_edges;
  logic [BUTTONS-1:0] button_release_edges;
  logic               beam_active;
  logic               beam_edge;
  logic [DIST_W-1:0]  echo_distance_held;
  logic               echo_active;
  logic               echo_edge;
  logic [SENSORS-1:0] sensor_detected;
  logic [SENSORS-1:0] sensor_pass_edges;
  logic [LIMITS-1:0]  limits_active;

  modport source (
    output valid, buttons_down, button_press_edges, button_release_edges,
           beam_active, beam_edge, echo_distance_held, echo_active, echo_edge,
           sensor_detected, sensor_pass_edges, limits_active,
    input  ready
  );
  modport sink (
    input  valid, buttons_down, button_press_edges, button_release_edges,
           beam_active, beam_edge, echo_distance_held, echo_active, echo_edge,
           sensor_detected, sensor_pass_edges, limits_active,
    output ready
  );
endinterface
`default_nettype wire

// ===== design/multi_input_debounce_edge_qualifier_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_input_debounce_edge_qualifier_top
// Per-tick qualifier for buttons, beam, limits, echo distance and sensors.
// ----------------------------------------------------------------------------
// The block takes one tick transaction every clock cycle while ready is high
// and returns its result from the output register; each button and sensor has
// its own lane, and all lane state updates in the single cycle the transaction
// is accepted, which sets that rate. A skid stage behind the output register
// lets the block accept one more transaction while a result waits; ready drops
// only when both are full. Registers sit at byte address 4*i on a 32-bit APB
// port (8*i on a 64-bit port when the packed thresholds exceed 32 bits); the
// user must write them only while no tick is in flight; nothing enforces it.
// ----------------------------------------------------------------------------
module multi_input_debounce_edge_qualifier_top
  import mideq_pkg::*;
#(
  parameter  int BUTTONS    = BUTTONS_DEF,
  parameter  int SENSORS    = SENSORS_DEF,
  parameter  int LIMITS     = LIMITS_DEF,
  localparam int POL_W      = POL_SENSOR_LSB + SENSORS,
  localparam int THR_W      = ANALOG_BITS * SENSORS,
  localparam int CFG_DATA_W = (THR_W > 32) ? 64 : 32,
  localparam int CFG_LSB    = (THR_W > 32) ? 3 : 2,
  localparam int CFG_ADDR_W = CFG_LSB + REG_IDX_W
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mideq_in_if.sink                   in_ch,
  mideq_out_if.source                out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);
  logic [MS_W-1:0]      debounce_r;
  logic [POL_W-1:0]     pol_r;
  logic [SENSORS-1:0]   mode_r;
  logic [THR_W-1:0]     thr_r;
  logic [MS_W-1:0]      lockout_r;
  logic [MS_W-1:0]      interval_r;
  logic [MS_W-1:0]      delta_r;
  logic                 beam_prev_r;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 in_fire;
  logic                 take_ok;
  echo_cfg_t            echo_cfg;

  logic [BUTTONS-1:0]   btn_down;
  logic [BUTTONS-1:0]   btn_press;
  logic [BUTTONS-1:0]   btn_rel;
  logic [SENSORS-1:0]   sns_det;
  logic [SENSORS-1:0]   sns_pass;
  logic                 beam_act;
  logic                 beam_rise;
  logic [LIMITS-1:0]    lim_act;
  logic [DIST_W-1:0]    echo_held;
  logic                 echo_act;
  logic                 echo_rise;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_LSB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      pol_r      <= '0;
      mode_r     <= '0;
      thr_r      <= '0;
      lockout_r  <= '0;
      interval_r <= '0;
      delta_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE:  debounce_r <= pwdata[MS_W-1:0];
        REG_POLARITY:  pol_r      <= pwdata[POL_W-1:0];
        REG_SNS_MODE:  mode_r     <= pwdata[SENSORS-1:0];
        REG_SNS_THR:   thr_r      <= pwdata[THR_W-1:0];
        REG_LOCKOUT:   lockout_r  <= pwdata[MS_W-1:0];
        REG_ECHO_INTV: interval_r <= pwdata[MS_W-1:0];
        REG_ECHO_DLT:  delta_r    <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_DEBOUNCE:  prdata[MS_W-1:0]    = debounce_r;
      REG_POLARITY:  prdata[POL_W-1:0]   = pol_r;
      REG_SNS_MODE:  prdata[SENSORS-1:0] = mode_r;
      REG_SNS_THR:   prdata[THR_W-1:0]   = thr_r;
      REG_LOCKOUT:   prdata[MS_W-1:0]    = lockout_r;
      REG_ECHO_INTV: prdata[MS_W-1:0]    = interval_r;
      REG_ECHO_DLT:  prdata[MS_W-1:0]    = delta_r;
      default:       prdata              = '0;
    endcase
  end

  assign in_ch.ready = take_ok;
  assign in_fire     = in_ch.valid & take_ok;

  for (genvar b = 0; b < BUTTONS; b++) begin : g_btn
    mideq_btn_lane u_btn (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (in_fire),
      .now_ms     (in_ch.now_ms),
      .raw_level  (in_ch.button_levels[b]),
      .active_low (pol_r[POL_BUTTON]),
      .window     (debounce_r),
      .down       (btn_down[b]),
      .press_edge (btn_press[b]),
      .rel_edge   (btn_rel[b])
    );
  end

  for (genvar s = 0; s < SENSORS; s++) begin : g_sns
    mideq_sns_lane u_sns (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (in_fire),
      .now_ms       (in_ch.now_ms),
      .dig_level    (in_ch.sensor_digital_levels[s]),
      .raw_value    (in_ch.sensor_raw_values[s*ANALOG_BITS +: ANALOG_BITS]),
      .threshold    (thr_r[s*ANALOG_BITS +: ANALOG_BITS]),
      .digital_mode (mode_r[s]),
      .active_low   (pol_r[POL_SENSOR_LSB + s]),
      .lockout      (lockout_r),
      .detected     (sns_det[s]),
      .pass_edge    (sns_pass[s])
    );
  end

  assign echo_cfg.interval = interval_r;
  assign echo_cfg.delta    = delta_r;

  mideq_echo u_echo (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (in_fire),
    .now_ms    (in_ch.now_ms),
    .dist_cm   (in_ch.echo_distance_cm),
    .cfg       (echo_cfg),
    .held      (echo_held),
    .active    (echo_act),
    .echo_rise (echo_rise)
  );

  assign beam_act  = in_ch.beam_level ^ pol_r[POL_BEAM];
  assign beam_rise = beam_act & ~beam_prev_r;
  assign lim_act   = in_ch.limit_levels ^ {LIMITS{pol_r[POL_LIMIT]}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_prev_r <= 1'b0;
    end else if (in_fire) begin
      beam_prev_r <= beam_act;
    end
  end

  mideq_merge #(
    .BUTTONS (BUTTONS),
    .SENSORS (SENSORS),
    .LIMITS  (LIMITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .take_ok   (take_ok),
    .btn_down  (btn_down),
    .btn_press (btn_press),
    .btn_rel   (btn_rel),
    .beam_act  (beam_act),
    .beam_rise (beam_rise),
    .echo_held (echo_held),
    .echo_act  (echo_act),
    .echo_rise (echo_rise),
    .sns_det   (sns_det),
    .sns_pass  (sns_pass),
    .lim_act   (lim_act),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

// ===== design/mideq_btn_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mideq_btn_lane
// One button: time-window debounce with press and release pulses.
// ----------------------------------------------------------------------------
module mideq_btn_lane
  import mideq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic              raw_level,
  input  wire logic              active_low,
  input  wire logic [MS_W-1:0]   window,
  output logic                   down,
  output logic                   press_edge,
  output logic                   rel_edge
);
  logic              raw_last_r;
  logic              stable_r;
  logic [TIME_W-1:0] chg_time_r;
  logic              raw;
  logic [TIME_W-1:0] chg_time_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              upd;
  logic              stable_nxt;

  assign raw          = raw_level ^ active_low;
  assign chg_time_nxt = (raw != raw_last_r) ? now_ms : chg_time_r;
  assign elapsed      = now_ms - chg_time_nxt;
  assign upd          = (elapsed >= TIME_W'(window)) && (raw != stable_r);
  assign stable_nxt   = upd ? raw : stable_r;

  assign down       = stable_nxt;
  assign press_edge = upd & raw;
  assign rel_edge   = upd & ~raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_last_r <= 1'b0;
      stable_r   <= 1'b0;
      chg_time_r <= '0;
    end else if (en) begin
      raw_last_r <= raw;
      stable_r   <= stable_nxt;
      chg_time_r <= chg_time_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/mideq_sns_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mideq_sns_lane
// One reflective sensor: digital or threshold detect, pass edge with lockout.
// ----------------------------------------------------------------------------
module mideq_sns_lane
  import mideq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic [TIME_W-1:0]      now_ms,
  input  wire logic                   dig_level,
  input  wire logic [ANALOG_BITS-1:0] raw_value,
  input  wire logic [ANALOG_BITS-1:0] threshold,
  input  wire logic                   digital_mode,
  input  wire logic                   active_low,
  input  wire logic [MS_W-1:0]        lockout,
  output logic                        detected,
  output logic                        pass_edge
);
  logic              prev_det_r;
  logic [TIME_W-1:0] event_time_r;
  logic              det;
  logic              analog_det;
  logic [TIME_W-1:0] elapsed;

  assign analog_det = active_low ? (raw_value <= threshold) : (raw_value >= threshold);
  assign det        = digital_mode ? (dig_level ^ active_low) : analog_det;
  assign elapsed    = now_ms - event_time_r;
  assign pass_edge  = det && !prev_det_r && (elapsed >= TIME_W'(lockout));
  assign detected   = det;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_det_r   <= 1'b0;
      event_time_r <= '0;
    end else if (en) begin
      prev_det_r <= det;
      if (pass_edge) begin
        event_time_r <= now_ms;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/mideq_echo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mideq_echo
// Echo distance resampling and change-by-delta activity detect.
// ----------------------------------------------------------------------------
module mideq_echo
  import mideq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [DIST_W-1:0] dist_cm,
  input  wire echo_cfg_t         cfg,
  output logic [DIST_W-1:0]      held,
  output logic                   active,
  output logic                   echo_rise
);
  logic [TIME_W-1:0]    sample_time_r;
  logic [DIST_W-1:0]    held_r;
  logic                 has_ref_r;
  logic [DIST_W-1:0]    ref_r;
  logic                 prev_act_r;
  logic [TIME_W-1:0]    elapsed;
  logic                 resample;
  logic [DIST_W-1:0]    held_nxt;
  logic [DIST_W-1:0]    diff;
  logic [DIFF_MM_W-1:0] diff_mm;
  logic                 act;

  assign elapsed  = now_ms - sample_time_r;
  assign resample = (elapsed >= TIME_W'(cfg.interval)) || (sample_time_r == '0);
  assign held_nxt = resample ? dist_cm : held_r;
  assign diff     = (held_nxt > ref_r) ? (held_nxt - ref_r) : (ref_r - held_nxt);
  assign diff_mm  = DIFF_MM_W'(diff) * DIFF_MM_W'(MM_PER_CM);
  assign act      = (held_nxt != '0) && has_ref_r && (diff_mm >= DIFF_MM_W'(cfg.delta));

  assign held      = held_nxt;
  assign active    = act;
  assign echo_rise = act & ~prev_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_time_r <= '0;
      held_r        <= '0;
      has_ref_r     <= 1'b0;
      ref_r         <= '0;
      prev_act_r    <= 1'b0;
    end else if (en) begin
      held_r     <= held_nxt;
      prev_act_r <= act;
      if (resample) begin
        sample_time_r <= now_ms;
      end
      if (held_nxt != '0) begin
        ref_r     <= held_nxt;
        has_ref_r <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/mideq_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mideq_merge
// Collect lane results into one transaction; output register plus skid stage.
// ----------------------------------------------------------------------------
module mideq_merge
  import mideq_pkg::*;
#(
  parameter int BUTTONS = BUTTONS_DEF,
  parameter int SENSORS = SENSORS_DEF,
  parameter int LIMITS  = LIMITS_DEF
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  output logic                    take_ok,
  input  wire logic [BUTTONS-1:0] btn_down,
  input  wire logic [BUTTONS-1:0] btn_press,
  input  wire logic [BUTTONS-1:0] btn_rel,
  input  wire logic               beam_act,
  input  wire logic               beam_rise,
  input  wire logic [DIST_W-1:0]  echo_held,
  input  wire logic               echo_act,
  input  wire logic               echo_rise,
  input  wire logic [SENSORS-1:0] sns_det,
  input  wire logic [SENSORS-1:0] sns_pass,
  input  wire logic [LIMITS-1:0]  lim_act,
  mideq_out_if.source             out_ch
);
  localparam int RES_W = 3*BUTTONS + DIST_W + 4 + 2*SENSORS + LIMITS;

  logic             out_valid_r;
  logic [RES_W-1:0] out_data_r;
  logic             skid_valid_r;
  logic [RES_W-1:0] skid_data_r;
  logic [RES_W-1:0] res;
  logic             out_free;

  assign res = {btn_down, btn_press, btn_rel, beam_act, beam_rise, echo_held,
                echo_act, echo_rise, sns_det, sns_pass, lim_act};

  assign take_ok  = ~skid_valid_r;
  assign out_free = ~out_valid_r | out_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign {out_ch.buttons_down, out_ch.button_press_edges, out_ch.button_release_edges,
          out_ch.beam_active, out_ch.beam_edge, out_ch.echo_distance_held,
          out_ch.echo_active, out_ch.echo_edge, out_ch.sensor_detected,
          out_ch.sensor_pass_edges, out_ch.limits_active} = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire) begin
        out_data_r <= res;
      end
    end else if (in_fire) begin
      skid_data_r <= res;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a transaction while the output stage is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && in_fire) |=> (skid_valid_r && out_valid_r))
    else $error("transaction accepted during output stall was not held");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ch.ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid stage did not advance into the output stage");

  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled output transaction changed");
endmodule
`default_nettype wire
